/* rtl/mme_pkg.sv */
package mme_pkg;

   localparam int DIM_W  = 4;
   localparam int IDX_W  = 3;
   localparam int ELEM_W = 16;
   localparam int PROD_W = 32;
   localparam int SUM_W  = 35;
   localparam int CSR_IDX_W = 2;

   localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;
   localparam logic [DIM_W-1:0] DIM_ONE   = 4'd1;

   typedef enum logic [1:0] {
      OP_LOAD_A  = 2'd0,
      OP_LOAD_B  = 2'd1,
      OP_COMPUTE = 2'd2,
      OP_NONE    = 2'd3
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS_A    = 2'd0,
      CSR_INNER_LEN = 2'd1,
      CSR_COLS_B    = 2'd2,
      CSR_UNUSED    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             first;
      logic             done;
      logic             last;
      logic [IDX_W-1:0] row;
      logic [IDX_W-1:0] col;
   } tag_type;

   typedef struct packed {
      logic             valid;
      tag_type          tag;
      logic [DIM_W-1:0] inner;
   } issue_type;

   typedef struct packed {
      logic wr_a;
      logic wr_b;
   } load_type;

   function automatic logic [DIM_W-1:0] clamp_dim(logic [DIM_W-1:0] value, int maxv);
      logic [DIM_W-1:0] result;
      result = value;
      if (value == '0) begin
         result = DIM_ONE;
      end else if (int'(value) > maxv) begin
         result = DIM_W'(maxv);
      end
      return result;
   endfunction

endpackage

/* rtl/mme_ram.sv */
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/mme_ctrl.sv */
module mme_ctrl #(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_INNER = 8,
   parameter int MAX_COLS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_opcode,
   input  logic                                 csr_write,
   input  logic [mme_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mme_pkg::DIM_W-1:0]            csr_data,
   input  logic                                 advance,
   output mme_pkg::load_type                    load,
   output mme_pkg::issue_type                   issue
);

   import mme_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_RUN  = 2'b10
   } state_type;

   state_type        state_ff, state_in;
   logic [DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [DIM_W-1:0] inner_len_ff, inner_len_in;
   logic [DIM_W-1:0] cols_b_ff, cols_b_in;
   logic [DIM_W-1:0] m_ff, m_in;
   logic [DIM_W-1:0] k_ff, k_in;
   logic [DIM_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] i_ff, i_in;
   logic [IDX_W-1:0] j_ff, j_in;
   logic [DIM_W-1:0] t_ff, t_in;
   logic             accept;
   logic             t_end;
   logic             j_end;
   logic             i_end;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   assign t_end = (t_ff == k_ff - DIM_ONE);
   assign j_end = (DIM_W'(j_ff) == n_ff - DIM_ONE);
   assign i_end = (DIM_W'(i_ff) == m_ff - DIM_ONE);

   assign load.wr_a = accept && (req_opcode == OP_LOAD_A);
   assign load.wr_b = accept && (req_opcode == OP_LOAD_B);

   assign issue.valid     = (state_ff == ST_RUN);
   assign issue.tag.first = (t_ff == '0);
   assign issue.tag.done  = t_end;
   assign issue.tag.last  = t_end && j_end && i_end;
   assign issue.tag.row   = i_ff;
   assign issue.tag.col   = j_ff;
   assign issue.inner     = t_ff;

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_len_in = inner_len_ff;
      cols_b_in    = cols_b_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ROWS_A:    rows_a_in    = csr_data;
            CSR_INNER_LEN: inner_len_in = csr_data;
            CSR_COLS_B:    cols_b_in    = csr_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      k_in     = k_ff;
      n_in     = n_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      t_in     = t_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_opcode == OP_COMPUTE)) begin
               state_in = ST_RUN;
               m_in     = clamp_dim(rows_a_ff, MAX_ROWS);
               k_in     = clamp_dim(inner_len_ff, MAX_INNER);
               n_in     = clamp_dim(cols_b_ff, MAX_COLS);
               i_in     = '0;
               j_in     = '0;
               t_in     = '0;
            end
         end
         ST_RUN: begin
            if (advance) begin
               if (!t_end) begin
                  t_in = t_ff + DIM_ONE;
               end else begin
                  t_in = '0;
                  if (!j_end) begin
                     j_in = j_ff + IDX_W'(1);
                  end else begin
                     j_in = '0;
                     if (!i_end) begin
                        i_in = i_ff + IDX_W'(1);
                     end else begin
                        state_in = ST_IDLE;
                     end
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rows_a_ff    <= DIM_RESET;
         inner_len_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else begin
         state_ff     <= state_in;
         rows_a_ff    <= rows_a_in;
         inner_len_ff <= inner_len_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff <= m_in;
      k_ff <= k_in;
      n_ff <= n_in;
      i_ff <= i_in;
      j_ff <= j_in;
      t_ff <= t_in;
   end

endmodule

/* rtl/mme_datapath.sv */
module mme_datapath #(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_INNER = 8,
   parameter int MAX_COLS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  mme_pkg::load_type                    load,
   input  mme_pkg::issue_type                   issue,
   input  logic [mme_pkg::IDX_W-1:0]            req_row_index,
   input  logic [mme_pkg::IDX_W-1:0]            req_col_index,
   input  logic signed [mme_pkg::ELEM_W-1:0]    req_elem_value,
   output logic                                 advance,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mme_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [mme_pkg::IDX_W-1:0]            rsp_out_col,
   output logic signed [mme_pkg::SUM_W-1:0]     rsp_product_value,
   output logic                                 rsp_is_last
);

   import mme_pkg::*;

   localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
   localparam int B_DEPTH = MAX_INNER * MAX_COLS;
   localparam int A_AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int B_AW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

   logic [A_AW-1:0]          a_wr_addr;
   logic [A_AW-1:0]          a_rd_addr;
   logic [B_AW-1:0]          b_wr_addr;
   logic [B_AW-1:0]          b_rd_addr;
   logic                     a_wr_en;
   logic                     b_wr_en;
   logic                     rd_en;
   logic [ELEM_W-1:0]        a_rd_data;
   logic [ELEM_W-1:0]        b_rd_data;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [SUM_W-1:0]  sum_in;

   logic                     s1_valid_ff;
   tag_type                  s1_tag_ff;
   logic                     s2_valid_ff;
   tag_type                  s2_tag_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [SUM_W-1:0]  acc_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]         rsp_row_ff;
   logic [IDX_W-1:0]         rsp_col_ff;
   logic signed [SUM_W-1:0]  rsp_value_ff;
   logic                     rsp_last_ff;
   logic                     finish;

   assign advance = !(rsp_valid_ff && rsp_stall);

   assign a_wr_en = load.wr_a && (int'(req_row_index) < MAX_ROWS)
                    && (int'(req_col_index) < MAX_INNER);
   assign b_wr_en = load.wr_b && (int'(req_row_index) < MAX_INNER)
                    && (int'(req_col_index) < MAX_COLS);
   assign a_wr_addr = A_AW'(int'(req_row_index) * MAX_INNER + int'(req_col_index));
   assign b_wr_addr = B_AW'(int'(req_row_index) * MAX_COLS + int'(req_col_index));
   assign a_rd_addr = A_AW'(int'(issue.tag.row) * MAX_INNER + int'(issue.inner));
   assign b_rd_addr = B_AW'(int'(issue.inner) * MAX_COLS + int'(issue.tag.col));
   assign rd_en     = issue.valid && advance;

   mme_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (A_DEPTH)
   ) u_store_a (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (req_elem_value),
      .rd_en   (rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   mme_ram #(
      .WIDTH (ELEM_W),
      .DEPTH (B_DEPTH)
   ) u_store_b (
      .clock   (clock),
      .wr_en   (b_wr_en),
      .wr_addr (b_wr_addr),
      .wr_data (req_elem_value),
      .rd_en   (rd_en),
      .rd_addr (b_rd_addr),
      .rd_data (b_rd_data)
   );

   assign prod_in = $signed(a_rd_data) * $signed(b_rd_data);
   assign sum_in  = (s2_tag_ff.first ? SUM_W'(0) : acc_ff)
                    + {{(SUM_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign finish  = advance && s2_valid_ff && s2_tag_ff.done;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            s1_valid_ff <= rd_en;
            s2_valid_ff <= s1_valid_ff;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_tag_ff <= issue.tag;
         s2_tag_ff <= s1_tag_ff;
         prod_ff   <= prod_in;
         if (s2_valid_ff) begin
            acc_ff <= sum_in;
         end
      end
      if (finish) begin
         rsp_row_ff   <= s2_tag_ff.row;
         rsp_col_ff   <= s2_tag_ff.col;
         rsp_value_ff <= sum_in;
         rsp_last_ff  <= s2_tag_ff.last;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_row       = rsp_row_ff;
   assign rsp_out_col       = rsp_col_ff;
   assign rsp_product_value = rsp_value_ff;
   assign rsp_is_last       = rsp_last_ff;

endmodule

/* rtl/matrix_multiply_engine.sv */
// Load transfers are taken one per cycle while idle and write one element of
// A or B. A compute transfer occupies the sequencer until all m*n*k products
// are issued, reading one operand from each store per cycle unless a stalled
// result holds it; each element of C is a serial multiply-accumulate of k products.
// A stalled result freezes the read, multiply and accumulate pipeline.
// Reset is synchronous and restores all sizes to 8; the stores are not cleared.
module matrix_multiply_engine #(
   parameter int MAX_ROWS  = 8,
   parameter int MAX_INNER = 8,
   parameter int MAX_COLS  = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_opcode,
   input  logic [mme_pkg::IDX_W-1:0]            req_row_index,
   input  logic [mme_pkg::IDX_W-1:0]            req_col_index,
   input  logic signed [mme_pkg::ELEM_W-1:0]    req_elem_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [mme_pkg::IDX_W-1:0]            rsp_out_row,
   output logic [mme_pkg::IDX_W-1:0]            rsp_out_col,
   output logic signed [mme_pkg::SUM_W-1:0]     rsp_product_value,
   output logic                                 rsp_is_last,
   input  logic                                 csr_write,
   input  logic [mme_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [mme_pkg::DIM_W-1:0]            csr_data
);

   import mme_pkg::*;

   load_type  load;
   issue_type issue;
   logic      advance;

   mme_ctrl #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_INNER (MAX_INNER),
      .MAX_COLS  (MAX_COLS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_opcode (req_opcode),
      .csr_write  (csr_write),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .advance    (advance),
      .load       (load),
      .issue      (issue)
   );

   mme_datapath #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_INNER (MAX_INNER),
      .MAX_COLS  (MAX_COLS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .load              (load),
      .issue             (issue),
      .req_row_index     (req_row_index),
      .req_col_index     (req_col_index),
      .req_elem_value    (req_elem_value),
      .advance           (advance),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_out_row       (rsp_out_row),
      .rsp_out_col       (rsp_out_col),
      .rsp_product_value (rsp_product_value),
      .rsp_is_last       (rsp_is_last)
   );

endmodule

/* rtl/mme_checker.sv */
module mme_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_stall,
   input logic [1:0]                           req_opcode,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic [mme_pkg::IDX_W-1:0]            rsp_out_row,
   input logic [mme_pkg::IDX_W-1:0]            rsp_out_col,
   input logic signed [mme_pkg::SUM_W-1:0]     rsp_product_value,
   input logic                                 rsp_is_last
);

   import mme_pkg::*;

   logic req_transfer;

   assign req_transfer = req_valid && !req_stall;

   // No result is pending right after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // A compute transfer blocks further requests while its products are issued.
   assert property (@(posedge clock) disable iff (reset)
      req_transfer && (req_opcode == OP_COMPUTE) |=> req_stall)
      else $error("request accepted during compute");

   // Loads and idle opcodes never block the request channel.
   assert property (@(posedge clock) disable iff (reset)
      req_transfer && (req_opcode != OP_COMPUTE) |=> !req_stall)
      else $error("request channel blocked after load");

   // A stalled result holds until its transfer.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product_value)
      && $stable(rsp_out_row) && $stable(rsp_out_col) && $stable(rsp_is_last))
      else $error("stalled result changed");

endmodule

bind matrix_multiply_engine mme_checker u_checker (.*);
